FILE: design/hmn_pkg.sv
// Shared constants for the height map to normal map block.
package hmn_pkg;

    // Default line length and size of the line store rows
    localparam int DEFAULT_MAX_WIDTH = 1024;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BUMP_SCALE   = 2'd2;

    // Register reset values
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1;
    localparam logic [15:0] RST_BUMP_SCALE   = 16'd256;

    // z component (1.0 in the 255 * 256 scale) and its square
    localparam logic [22:0] Z_UNIT = 23'd65280;
    localparam logic [63:0] Z_SQ   = 64'd4261478400;

endpackage

FILE: design/heightmap_to_normal_map.sv
// Height map to normal map: line store, sequencer and serial arithmetic.
//
// Height bytes come in raster order; each one may release up to three normal pixels
// (the pixel above it, and on the last row the pixel to its left and the row's end).
// Each normal takes line store reads, the scaled gradients, their squares, and per
// component a binary search of 8 search probes. The one shift-add multiplier, which
// consumes one multiplier bit per cycle, bounds the speed of the whole block.
// The input is taken only while no normal of the previous height is in work;
// the last finished normal may still wait in the output register. The line store has
// undefined contents after reset and needs no clearing pass.
module heightmap_to_normal_map #(
    parameter int MAX_WIDTH = hmn_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // height input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_height,
    // normal output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [7:0]  o_normal_x,
    output logic [7:0]  o_normal_y,
    output logic [7:0]  o_normal_z,
    output logic        o_frame_done
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_JOB   = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_MDX   = 4'd3;
    localparam logic [3:0] ST_MDY   = 4'd4;
    localparam logic [3:0] ST_SQX   = 4'd5;
    localparam logic [3:0] ST_SQY   = 4'd6;
    localparam logic [3:0] ST_COMP  = 4'd7;
    localparam logic [3:0] ST_PROBE = 4'd8;
    localparam logic [3:0] ST_LHS   = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    // Configuration registers
    logic [10:0] r_image_width;
    logic [15:0] r_image_height;
    logic [15:0] r_bump_scale;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= hmn_pkg::RST_IMAGE_WIDTH;
            r_image_height <= hmn_pkg::RST_IMAGE_HEIGHT;
            r_bump_scale   <= hmn_pkg::RST_BUMP_SCALE;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                hmn_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[10:0];
                hmn_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[15:0];
                hmn_pkg::REG_BUMP_SCALE:   r_bump_scale   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            hmn_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, r_image_width};
            hmn_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, r_image_height};
            hmn_pkg::REG_BUMP_SCALE:   prdata = {16'd0, r_bump_scale};
            default:                   prdata = 32'd0;
        endcase
    end

    // Effective last column and last row
    logic [15:0]   w_ext;
    logic [CW-1:0] w_last;
    logic [15:0]   h_last;
    assign w_ext = {5'd0, r_image_width};
    always_comb begin
        if (w_ext > 16'(MAX_WIDTH))
            w_last = CW'(MAX_WIDTH - 1);
        else if (w_ext == 16'd0)
            w_last = '0;
        else
            w_last = CW'(w_ext - 16'd1);
        h_last = (r_image_height == 16'd0) ? 16'd0 : r_image_height - 16'd1;
    end

    // State registers
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_col_cnt;
    logic [15:0]   r_row_cnt;
    logic [1:0]    r_slot;

    // Parameters of the accepted height
    logic [CW-1:0] r_c;
    logic [15:0]   r_r;
    logic [CW-1:0] r_wm1;
    logic [2:0]    r_has;
    logic          r_rgt0, r_rgt1;
    logic [1:0]    r_s0, r_s1, r_s2;
    logic [1:0]    r_job;
    logic [2:0]    r_rd_cnt;
    logic [7:0]    r_h [0:3];

    logic in_acc;
    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && !o_stall;

    logic end_row, last_row;
    assign end_row  = (r_col_cnt >= w_last);
    assign last_row = (r_row_cnt >= h_last);

    function automatic logic [1:0] slot_dec(input logic [1:0] s);
        slot_dec = (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    // Neighborhood of the current job
    logic [CW-1:0] j_col, j_lc, j_rc;
    logic [15:0]   j_row;
    logic [1:0]    j_cs, j_us;
    logic          j_done;
    always_comb begin
        j_col  = r_c;
        j_row  = r_r;
        j_lc   = (r_c != '0) ? r_c - 1'b1 : r_c;
        j_rc   = r_c;
        j_cs   = r_s0;
        j_us   = r_rgt0 ? r_s1 : r_s0;
        j_done = 1'b0;
        unique case (r_job)
            2'd0: begin
                j_row = r_r - 16'd1;
                j_rc  = (r_c < r_wm1) ? r_c + 1'b1 : r_c;
                j_cs  = r_s1;
                j_us  = r_rgt1 ? r_s2 : r_s1;
            end
            2'd1: begin
                j_col = r_c - 1'b1;
                j_lc  = (r_c > CW'(1)) ? r_c - CW'(2) : r_c - 1'b1;
            end
            2'd2: j_done = 1'b1;
            default: ;
        endcase
    end

    // Line store read address
    logic [1:0]    rd_slot;
    logic [CW-1:0] rd_col;
    logic [AW-1:0] rd_base, rd_addr, wr_addr, wr_base;
    always_comb begin
        unique case (r_rd_cnt[1:0])
            2'd0: begin rd_slot = j_cs; rd_col = j_lc;  end
            2'd1: begin rd_slot = j_cs; rd_col = j_rc;  end
            2'd2: begin rd_slot = j_us; rd_col = j_col; end
            default: begin rd_slot = r_s0; rd_col = j_col; end
        endcase
        unique case (rd_slot)
            2'd1:    rd_base = AW'(MAX_WIDTH);
            2'd2:    rd_base = AW'(2 * MAX_WIDTH);
            default: rd_base = '0;
        endcase
        unique case (r_slot)
            2'd1:    wr_base = AW'(MAX_WIDTH);
            2'd2:    wr_base = AW'(2 * MAX_WIDTH);
            default: wr_base = '0;
        endcase
        rd_addr = rd_base + AW'(rd_col);
        wr_addr = wr_base + AW'(r_col_cnt);
    end

    // Line store memory
    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_mem[wr_addr] <= i_height;
        r_rdata <= r_mem[rd_addr];
    end

    // Gradients and scale magnitudes
    logic signed [8:0] dx, dy;
    logic [7:0]        dx_mag, dy_mag;
    logic              s_neg;
    logic [15:0]       s_mag;
    assign dx     = $signed({1'b0, r_h[0]}) - $signed({1'b0, r_h[1]});
    assign dy     = $signed({1'b0, r_h[2]}) - $signed({1'b0, r_h[3]});
    assign dx_mag = dx[8] ? 8'(-dx) : dx[7:0];
    assign dy_mag = dy[8] ? 8'(-dy) : dy[7:0];
    assign s_neg  = r_bump_scale[15];
    assign s_mag  = s_neg ? 16'(-r_bump_scale) : r_bump_scale;

    // Serial multiplier, one multiplier bit per cycle
    logic [63:0] r_ma, r_macc;
    logic [22:0] r_mb;
    logic        mul_busy;
    assign mul_busy = (r_mb != '0);

    // Arithmetic registers
    logic [22:0] r_mx, r_my;
    logic        r_negx, r_negy, r_neg;
    logic [45:0] r_sqx, r_sqy;
    logic [47:0] r_q;
    logic [63:0] r_rhs;
    logic [1:0]  r_cmp;
    logic [7:0]  r_lo, r_hi, r_mid;
    logic        r_apos;
    logic [7:0]  r_bx, r_by, r_bz;

    // Search probe
    logic [7:0]  mid;
    logic        apos;
    logic [7:0]  amag;
    logic [15:0] asq;
    logic [45:0] cmp_sq;
    logic        cmp_neg;
    logic        lhs_ok;
    always_comb begin
        mid  = 8'((9'(r_lo) + 9'(r_hi) + 9'd1) >> 1);
        apos = mid[7];
        amag = apos ? 8'({mid, 1'b0} - 9'd255) : 8'(9'd255 - {mid, 1'b0});
        asq  = 16'(amag * amag);
        unique case (r_cmp)
            2'd0:    begin cmp_sq = r_sqx; cmp_neg = r_negx; end
            2'd1:    begin cmp_sq = r_sqy; cmp_neg = r_negy; end
            default: begin cmp_sq = 46'(hmn_pkg::Z_SQ); cmp_neg = 1'b0; end
        endcase
        lhs_ok = r_apos ? (r_macc <= r_rhs) : (r_macc >= r_rhs);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_JOB;
            ST_JOB: begin
                if (r_job == 2'd3)
                    n_state = ST_IDLE;
                else if (r_has[r_job])
                    n_state = ST_READ;
            end
            ST_READ:  if (r_rd_cnt == 3'd4) n_state = ST_MDX;
            ST_MDX:   if (!mul_busy) n_state = ST_MDY;
            ST_MDY:   if (!mul_busy) n_state = ST_SQX;
            ST_SQX:   if (!mul_busy) n_state = ST_SQY;
            ST_SQY:   if (!mul_busy) n_state = ST_COMP;
            ST_COMP:  n_state = ST_PROBE;
            ST_PROBE: begin
                if (r_lo == r_hi)
                    n_state = (r_cmp == 2'd2) ? ST_EMIT : ST_COMP;
                else if (apos == cmp_neg)
                    n_state = ST_PROBE;
                else
                    n_state = ST_LHS;
            end
            ST_LHS:   if (!mul_busy) n_state = ST_PROBE;
            ST_EMIT:  if (!o_valid || !i_stall) n_state = ST_JOB;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_slot    <= 2'd0;
            r_job     <= 2'd0;
            r_rd_cnt  <= 3'd0;
            r_has     <= 3'd0;
            o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            // frame position and slot of the next height
            if (in_acc) begin
                r_job <= 2'd0;
                r_has <= {last_row && end_row, last_row && (r_col_cnt != '0),
                          r_row_cnt != 16'd0};
                if (end_row) begin
                    r_col_cnt <= '0;
                    if (last_row) begin
                        r_row_cnt <= '0;
                        r_slot    <= 2'd0;
                    end else begin
                        r_row_cnt <= r_row_cnt + 16'd1;
                        r_slot    <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
                    end
                end else begin
                    r_col_cnt <= r_col_cnt + 1'b1;
                end
            end
            if (r_state == ST_JOB && r_job != 2'd3 && !r_has[r_job])
                r_job <= r_job + 2'd1;
            if (r_state == ST_READ)
                r_rd_cnt <= (r_rd_cnt == 3'd4) ? 3'd0 : r_rd_cnt + 3'd1;
            // output register
            if (r_state == ST_EMIT && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1;
                r_job   <= r_job + 2'd1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // capture of the accepted position
        if (in_acc) begin
            r_c    <= r_col_cnt;
            r_r    <= r_row_cnt;
            r_wm1  <= w_last;
            r_rgt0 <= (r_row_cnt != 16'd0);
            r_rgt1 <= (r_row_cnt > 16'd1);
            r_s0   <= r_slot;
            r_s1   <= slot_dec(r_slot);
            r_s2   <= slot_dec(slot_dec(r_slot));
        end

        // multiplier step; idle out of reset
        if (!i_rst_n) begin
            r_mb <= '0;
        end else if (mul_busy) begin
            r_macc <= r_macc + (r_mb[0] ? r_ma : 64'd0);
            r_ma   <= r_ma << 1;
            r_mb   <= r_mb >> 1;
        end

        unique case (r_state)
            ST_READ: begin
                if (r_rd_cnt != 3'd0)
                    r_h[r_rd_cnt[1:0] - 2'd1] <= r_rdata;
            end
            default: ;
        endcase

        unique case (r_state)
            ST_READ: begin
                if (r_rd_cnt == 3'd4) begin
                    r_ma   <= 64'(s_mag);
                    r_mb   <= 23'(dx_mag);
                    r_macc <= 64'd0;
                end
            end
            ST_MDX: begin
                if (!mul_busy) begin
                    r_mx   <= r_macc[22:0];
                    r_negx <= (r_macc != 64'd0) && (dx[8] ^ s_neg);
                    r_ma   <= 64'(s_mag);
                    r_mb   <= 23'(dy_mag);
                    r_macc <= 64'd0;
                end
            end
            ST_MDY: begin
                if (!mul_busy) begin
                    r_my   <= r_macc[22:0];
                    r_negy <= (r_macc != 64'd0) && (dy[8] ^ s_neg);
                    r_ma   <= 64'(r_mx);
                    r_mb   <= r_mx;
                    r_macc <= 64'd0;
                end
            end
            ST_SQX: begin
                if (!mul_busy) begin
                    r_sqx  <= r_macc[45:0];
                    r_ma   <= 64'(r_my);
                    r_mb   <= r_my;
                    r_macc <= 64'd0;
                end
            end
            ST_SQY: begin
                if (!mul_busy) begin
                    r_sqy <= r_macc[45:0];
                    r_q   <= 48'(r_sqx) + 48'(r_macc[45:0]) + 48'(hmn_pkg::Z_SQ);
                    r_cmp <= 2'd0;
                end
            end
            ST_COMP: begin
                // 65025 * V^2 for the component under search (65536 - 512 + 1)
                r_rhs <= (64'(cmp_sq) << 16) - (64'(cmp_sq) << 9) + 64'(cmp_sq);
                r_neg <= cmp_neg;
                r_lo  <= 8'd0;
                r_hi  <= 8'd255;
            end
            ST_PROBE: begin
                if (r_lo == r_hi) begin
                    unique case (r_cmp)
                        2'd0:    r_bx <= r_lo;
                        2'd1:    r_by <= r_lo;
                        default: r_bz <= r_lo;
                    endcase
                    r_cmp <= r_cmp + 2'd1;
                end else if (apos && r_neg) begin
                    // positive level above a negative component
                    r_hi <= mid - 8'd1;
                end else if (!apos && !r_neg) begin
                    // negative level below a non-negative component
                    r_lo <= mid;
                end else begin
                    r_mid  <= mid;
                    r_apos <= apos;
                    r_ma   <= 64'(r_q);
                    r_mb   <= 23'(asq);
                    r_macc <= 64'd0;
                end
            end
            ST_LHS: begin
                if (!mul_busy) begin
                    if (lhs_ok)
                        r_lo <= r_mid;
                    else
                        r_hi <= r_mid - 8'd1;
                end
            end
            ST_EMIT: begin
                if (!o_valid || !i_stall) begin
                    o_pos_x      <= 10'(j_col);
                    o_pos_y      <= j_row;
                    o_normal_x   <= r_bx;
                    o_normal_y   <= r_by;
                    o_normal_z   <= r_bz;
                    o_frame_done <= j_done;
                end
            end
            default: ;
        endcase
    end

    // Checks on the sequencer
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LHS || r_state == ST_PROBE) |-> (r_lo <= r_hi))
        else $error("search bounds crossed");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col_cnt) < MAX_WIDTH)
        else $error("column counter past line length");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("line store slot out of range");

    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_EMIT) |-> !mul_busy)
        else $error("multiplier busy outside arithmetic");

endmodule
